FILE: hw/rtl/serial_bank_switch_mapper_unit_macros.svh
// Assertion macros used by the bank mapper top level.
`ifndef SERIAL_BANK_SWITCH_MAPPER_UNIT_MACROS_SVH
`define SERIAL_BANK_SWITCH_MAPPER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBSM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/sbsm_pkg.sv
// Types and constants of the serial bank switch mapper.
package sbsm_pkg;

   localparam int KIND_W   = 2;
   localparam int ADDR_W   = 15;
   localparam int DATA_W   = 8;
   localparam int TARGET_W = 2;
   localparam int MADDR_W  = 18;
   localparam int REG_W    = 5;
   localparam int COUNT_W  = 3;
   localparam int BANK_W   = 4;

   // Transaction kinds on the request channel.
   localparam logic [KIND_W-1:0] KIND_PRG_READ  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PRG_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CHR_READ  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CHR_WRITE = 2'd3;

   // Memory targets on the response channel.
   localparam logic [TARGET_W-1:0] TARGET_NONE      = 2'd0;
   localparam logic [TARGET_W-1:0] TARGET_PRG_READ  = 2'd1;
   localparam logic [TARGET_W-1:0] TARGET_CHR_READ  = 2'd2;
   localparam logic [TARGET_W-1:0] TARGET_CHR_WRITE = 2'd3;

   // Register selected by address bits 14:13 on the fifth serial bit.
   localparam logic [1:0] SEL_CONTROL  = 2'd0;
   localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
   localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
   localparam logic [1:0] SEL_PRG_PAGE = 2'd3;

   // Program banking modes from control bits 3:2.
   localparam logic [1:0] PRG_MODE_32K_A     = 2'd0;
   localparam logic [1:0] PRG_MODE_32K_B     = 2'd1;
   localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
   localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

   localparam logic [REG_W-1:0]   CONTROL_RESET        = 5'h0C;
   localparam logic [REG_W-1:0]   PRG_PAGE_COUNT_RESET = 5'd16;
   localparam logic [COUNT_W-1:0] SERIAL_LAST          = 3'd4;
   localparam int                 RESET_BIT            = 7;
   localparam int                 CHR_4K_MODE_BIT      = 4;

   typedef struct packed {
      logic [REG_W-1:0] control;
      logic [REG_W-1:0] chr_low;
      logic [REG_W-1:0] chr_high;
      logic [REG_W-1:0] prg_page;
   } sbsm_banks_type;

   localparam sbsm_banks_type BANKS_RESET = '{
      control:  CONTROL_RESET,
      chr_low:  '0,
      chr_high: '0,
      prg_page: '0
   };

   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic [MADDR_W-1:0]  memory_address;
      logic [DATA_W-1:0]   write_data;
   } sbsm_result_type;

endpackage

FILE: hw/rtl/sbsm_req_if.sv
// Request channel: bus accesses into the mapper.
interface sbsm_req_if;
   import sbsm_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] data;

   modport source (output valid, output kind, output address, output data, input ready);
   modport sink   (input valid, input kind, input address, input data, output ready);
endinterface

FILE: hw/rtl/sbsm_rsp_if.sv
// Response channel: translated memory accesses out of the mapper.
interface sbsm_rsp_if;
   import sbsm_pkg::*;

   logic                valid;
   logic                ready;
   logic [TARGET_W-1:0] target;
   logic [MADDR_W-1:0]  memory_address;
   logic [DATA_W-1:0]   write_data;

   modport source (output valid, output target, output memory_address, output write_data,
                   input ready);
   modport sink   (input valid, input target, input memory_address, input write_data,
                   output ready);
endinterface

FILE: hw/rtl/sbsm_serial_loader.sv
// Five-bit serial loader and the bank registers it writes.
module sbsm_serial_loader (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            write_valid,
   input  logic [1:0]                      write_select,
   input  logic [sbsm_pkg::DATA_W-1:0]     write_data,
   output sbsm_pkg::sbsm_banks_type        banks,
   output logic [sbsm_pkg::COUNT_W-1:0]    serial_count
);
   import sbsm_pkg::*;

   logic [REG_W-1:0]   serial_bits_ff;
   logic [REG_W-1:0]   serial_bits_in;
   logic [COUNT_W-1:0] serial_count_ff;
   logic [COUNT_W-1:0] serial_count_in;
   sbsm_banks_type     banks_ff;
   sbsm_banks_type     banks_in;
   logic [REG_W-1:0]   shifted_bits;

   always_comb begin
      shifted_bits    = serial_bits_ff | ({{(REG_W-1){1'b0}}, write_data[0]} << serial_count_ff);
      serial_bits_in  = serial_bits_ff;
      serial_count_in = serial_count_ff;
      banks_in        = banks_ff;
      if (write_valid) begin
         if (write_data[RESET_BIT]) begin
            serial_bits_in  = '0;
            serial_count_in = '0;
            banks_in        = BANKS_RESET;
         end else if (serial_count_ff == SERIAL_LAST) begin
            // Fifth bit: the assembled value lands in the selected register.
            unique case (write_select)
               SEL_CONTROL:  banks_in.control  = shifted_bits;
               SEL_CHR_LOW:  banks_in.chr_low  = shifted_bits;
               SEL_CHR_HIGH: banks_in.chr_high = shifted_bits;
               SEL_PRG_PAGE: banks_in.prg_page = shifted_bits;
            endcase
            serial_bits_in  = '0;
            serial_count_in = '0;
         end else begin
            serial_bits_in  = shifted_bits;
            serial_count_in = serial_count_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         serial_bits_ff  <= '0;
         serial_count_ff <= '0;
         banks_ff        <= BANKS_RESET;
      end else begin
         serial_bits_ff  <= serial_bits_in;
         serial_count_ff <= serial_count_in;
         banks_ff        <= banks_in;
      end
   end

   assign banks        = banks_ff;
   assign serial_count = serial_count_ff;
endmodule

FILE: hw/rtl/sbsm_translate.sv
// Address decode from window offsets to physical program or character addresses.
module sbsm_translate (
   input  logic [sbsm_pkg::KIND_W-1:0] kind,
   input  logic [sbsm_pkg::ADDR_W-1:0] address,
   input  logic [sbsm_pkg::DATA_W-1:0] data,
   input  sbsm_pkg::sbsm_banks_type    banks,
   input  logic [sbsm_pkg::BANK_W-1:0] fixed_bank,
   output sbsm_pkg::sbsm_result_type   result
);
   import sbsm_pkg::*;

   logic [1:0]         prg_mode;
   logic [BANK_W-1:0]  prg_select;
   logic               prg_upper;
   logic [MADDR_W-1:0] prg_address;
   logic [REG_W-1:0]   chr_page;
   logic [MADDR_W-1:0] chr_address;

   always_comb begin
      prg_mode   = banks.control[3:2];
      prg_select = banks.prg_page[BANK_W-1:0];
      prg_upper  = address[14];
      unique case (prg_mode)
         PRG_MODE_32K_A,
         PRG_MODE_32K_B: begin
            // 32 KiB banking ignores the low bank bit.
            prg_address = {prg_select[BANK_W-1:1], address[14:0]};
         end
         PRG_MODE_FIX_FIRST: begin
            prg_address = prg_upper ? {prg_select, address[13:0]}
                                    : {{BANK_W{1'b0}}, address[13:0]};
         end
         PRG_MODE_FIX_LAST: begin
            prg_address = prg_upper ? {fixed_bank, address[13:0]}
                                    : {prg_select, address[13:0]};
         end
      endcase

      chr_page = address[12] ? banks.chr_high : banks.chr_low;
      if (banks.control[CHR_4K_MODE_BIT]) begin
         chr_address = {1'b0, chr_page, address[11:0]};
      end else begin
         chr_address = {1'b0, banks.chr_low[REG_W-1:1], address[12:0]};
      end

      unique case (kind)
         KIND_PRG_READ: begin
            result = '{target: TARGET_PRG_READ, memory_address: prg_address,
                       write_data: '0};
         end
         KIND_PRG_WRITE: begin
            result = '{target: TARGET_NONE, memory_address: '0, write_data: '0};
         end
         KIND_CHR_READ: begin
            result = '{target: TARGET_CHR_READ, memory_address: chr_address,
                       write_data: '0};
         end
         KIND_CHR_WRITE: begin
            result = '{target: TARGET_CHR_WRITE, memory_address: chr_address,
                       write_data: data};
         end
      endcase
   end
endmodule

FILE: hw/rtl/serial_bank_switch_mapper_unit.sv
// Top level of the serial bank switch mapper.
//
// The mapper takes one bus transaction per clock and returns exactly one response
// transaction for each, in order: the request is captured in an input register,
// decoded in a single combinational pass against the bank registers, and the result
// is held in an output register. Throughput is one transaction per cycle; the only
// limit is the response side taking results. A program-window write updates the serial
// loader when it leaves the input register, so the very next transaction already sees
// the new bank state. Its response carries target zero. The bank count register's last
// bank serves as the fixed upper bank in mode three. The user must write that register
// through the csr port only while the mapper is idle; the block does not enforce this.
`include "serial_bank_switch_mapper_unit_macros.svh"

module serial_bank_switch_mapper_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [sbsm_pkg::REG_W-1:0]     csr_write_data,
   sbsm_req_if.sink                       req_chan,
   sbsm_rsp_if.source                     rsp_chan
);
   import sbsm_pkg::*;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [KIND_W-1:0] in_kind_ff;
   logic [ADDR_W-1:0] in_address_ff;
   logic [DATA_W-1:0] in_data_ff;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   sbsm_result_type   rsp_result_ff;
   sbsm_result_type   decode_result;

   logic [REG_W-1:0]   prg_page_count_ff;
   logic [REG_W-1:0]   fixed_sum;
   logic [BANK_W-1:0]  fixed_bank;

   logic               advance;
   logic               req_accept;
   logic               loader_step;
   sbsm_banks_type     banks;
   logic [COUNT_W-1:0] serial_count;

   // The pipeline moves whenever the output register is empty or being drained.
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign loader_step    = in_valid_ff && advance && (in_kind_ff == KIND_PRG_WRITE);

   assign fixed_sum  = prg_page_count_ff - 5'd1;
   assign fixed_bank = fixed_sum[BANK_W-1:0];

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         prg_page_count_ff <= PRG_PAGE_COUNT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            prg_page_count_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_kind_ff    <= req_chan.kind;
         in_address_ff <= req_chan.address;
         in_data_ff    <= req_chan.data;
      end
      if (advance && in_valid_ff) begin
         rsp_result_ff <= decode_result;
      end
   end

   sbsm_serial_loader u_loader (
      .clock        (clock),
      .reset        (reset),
      .write_valid  (loader_step),
      .write_select (in_address_ff[14:13]),
      .write_data   (in_data_ff),
      .banks        (banks),
      .serial_count (serial_count)
   );

   sbsm_translate u_translate (
      .kind       (in_kind_ff),
      .address    (in_address_ff),
      .data       (in_data_ff),
      .banks      (banks),
      .fixed_bank (fixed_bank),
      .result     (decode_result)
   );

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.target         = rsp_result_ff.target;
   assign rsp_chan.memory_address = rsp_result_ff.memory_address;
   assign rsp_chan.write_data     = rsp_result_ff.write_data;

   `SBSM_ASSERT_NEXT(a_stage_to_output, clock, reset, in_valid_ff && advance, rsp_valid_ff, "Transaction leaving the input register did not reach the output register.")
   `SBSM_ASSERT_NEXT(a_reset_write, clock, reset, loader_step && in_data_ff[RESET_BIT], banks == BANKS_RESET && serial_count == '0, "Reset write did not restore the bank registers.")
   `SBSM_ASSERT_NEXT(a_banks_hold, clock, reset, !loader_step, $stable(banks), "Bank registers changed without a program-window write.")
   `SBSM_ASSERT_SAME(a_count_range, clock, reset, 1'b1, serial_count <= SERIAL_LAST, "Serial loader count passed the fifth bit.")
endmodule
